// ===== design/wstt_pkg.sv =====
// Shared types and constants of the windowed slope trend tracker.
// Used by the top level and its checker; depends on nothing else.
`timescale 1ns / 1ps

package wstt_pkg;

	// One request on the input channel.
	typedef struct packed {
		logic [2:0]  channel;
		logic [15:0] sample;
	} in_item_t;

	// One result on the output channel.
	typedef struct packed {
		logic signed [25:0] slope;
		logic               stagnant;
		logic [6:0]         next_depth;
		logic [4:0]         sample_count;
	} out_item_t;

	// Configuration port.
	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_TREND_WINDOW = 2'd0;
	localparam logic [1:0] REG_MAX_DEPTH    = 2'd1;
	localparam logic [1:0] REG_STAG_FLOOR   = 2'd2;

	localparam logic [4:0]  TREND_WINDOW_RST = 5'd16;
	localparam logic [6:0]  MAX_DEPTH_RST    = 7'd3;
	localparam logic [15:0] STAG_FLOOR_RST   = 16'd17;

	// Slope arithmetic.
	localparam int SLOPE_W = 26;
	localparam int QUO_W   = 25;
	localparam logic [QUO_W-1:0] SLOPE_LIMIT = 25'd16777216;

	// Sample counts at which a fit and a stagnation verdict become meaningful.
	localparam int FIT_MIN_SAMPLES  = 2;
	localparam int STAG_MIN_SAMPLES = 3;

endpackage

// ===== design/wstt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the per-channel sample histories.
`timescale 1ns / 1ps

module wstt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/wstt_divider.sv =====
// Restoring divider producing one quotient bit per cycle, with overflow detection.
// Self-contained; used by the top level for the rounded slope quotient.
`timescale 1ns / 1ps

module wstt_divider #(
	parameter int DVD_W = 41,
	parameter int DVS_W = 21,
	parameter int Q_W   = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic             ovf,
	output logic [Q_W-1:0]   quotient
);

	localparam int W     = (DVD_W > DVS_W + Q_W) ? DVD_W : DVS_W + Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;
	logic             fits_w;

	assign fits_w = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(dividend);
			dvs_q <= W'(divisor) << (Q_W - 1);
			quo_q <= '0;
			// A quotient of Q_W bits is only exact when the dividend is below divisor * 2^Q_W.
			ovf_q <= W'(dividend) >= (W'(divisor) << Q_W);
		end else if (busy_q) begin
			if (fits_w) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[Q_W-2:0], fits_w};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done     = done_q;
	assign ovf      = ovf_q;
	assign quotient = quo_q;

endmodule

// ===== design/windowed_slope_trend_tracker_top.sv =====
// Top level of the windowed slope trend tracker: config registers, history walk and fit.
// Depends on wstt_pkg, wstt_ram and wstt_divider.
//
//   Channel   Handshake               Payload
//   config    psel/penable/pwrite     paddr, pwdata, prdata (3 registers, 32-bit)
//   input     in_valid / in_ready     wstt_pkg::in_item_t  (channel, sample)
//   output    out_valid / out_ready   wstt_pkg::out_item_t (slope, stagnant, depth, count)
//
// From acceptance, a request walks the history RAM one entry a cycle over the n samples
// now held (at most 16 with a sixteen-entry window), and the rounded quotient comes from
// a divider that yields one bit a cycle.
// A request naming a channel out of range skips the walk and goes to the final load.
// One request is worked on at a time; the next is taken while the result register still
// waits for out_ready, and only the final load of that register stalls behind it.
// Reset empties every history at once; the RAM itself is never cleared.
`timescale 1ns / 1ps

module windowed_slope_trend_tracker_top #(
	parameter int NUM_CHANNELS = 6,
	parameter int WINDOW_MAX   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wstt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  wstt_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output wstt_pkg::out_item_t          out_data
);

	localparam int CW     = $clog2(WINDOW_MAX + 1);
	localparam int IW     = $clog2(WINDOW_MAX);
	localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DEPTH  = NUM_CHANNELS * WINDOW_MAX;
	localparam int AW     = $clog2(DEPTH);
	localparam int SX_W   = 2 * CW;
	localparam int SXX_W  = 3 * CW;
	localparam int SY_W   = 16 + CW;
	localparam int SXY_W  = 16 + 2 * CW;
	localparam int P_W    = 16 + 3 * CW;
	localparam int DEN_W  = 4 * CW;
	localparam int DVD_W  = P_W + 10;
	localparam int DVS_W  = DEN_W + 1;
	localparam int QW     = wstt_pkg::QUO_W;
	localparam int SW     = wstt_pkg::SLOPE_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WRITE = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_SUB   = 3'd4;
	localparam logic [2:0] ST_START = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	// Configuration registers.
	logic [4:0]  trend_window_q;
	logic [6:0]  max_depth_q;
	logic [15:0] stag_floor_q;
	logic        cfg_wr_w;
	logic [1:0]  cfg_idx_w;

	assign cfg_wr_w  = psel && penable && pwrite;
	assign cfg_idx_w = paddr[wstt_pkg::PADDR_W-1:2];
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trend_window_q <= wstt_pkg::TREND_WINDOW_RST;
			max_depth_q    <= wstt_pkg::MAX_DEPTH_RST;
			stag_floor_q   <= wstt_pkg::STAG_FLOOR_RST;
		end else if (cfg_wr_w) begin
			case (cfg_idx_w)
				wstt_pkg::REG_TREND_WINDOW: trend_window_q <= pwdata[4:0];
				wstt_pkg::REG_MAX_DEPTH:    max_depth_q    <= pwdata[6:0];
				wstt_pkg::REG_STAG_FLOOR:   stag_floor_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx_w)
			wstt_pkg::REG_TREND_WINDOW: prdata = 32'(trend_window_q);
			wstt_pkg::REG_MAX_DEPTH:    prdata = 32'(max_depth_q);
			wstt_pkg::REG_STAG_FLOOR:   prdata = 32'(stag_floor_q);
			default:                    prdata = '0;
		endcase
	end

	// Control and datapath registers.
	logic [2:0]        state_q;
	logic [CHW-1:0]    ch_q;
	logic [15:0]       sample_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     k_q;
	logic [IW-1:0]     ptr_q;
	logic [IW-1:0]     heads_q [NUM_CHANNELS];
	logic [CW-1:0]     counts_q [NUM_CHANNELS];
	logic [SX_W-1:0]   sx_q;
	logic [SXX_W-1:0]  sxx_q;
	logic [SY_W-1:0]   sy_q;
	logic [SXY_W-1:0]  sxy_q;
	logic [P_W-1:0]    p1_q;
	logic [P_W-1:0]    p2_q;
	logic [DEN_W-1:0]  p3_q;
	logic [DEN_W-1:0]  p4_q;
	logic [P_W-1:0]    mag_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	logic [SW-1:0]     slope_q;
	wstt_pkg::out_item_t out_q;
	logic              out_valid_q;

	// History RAM.
	logic              ram_we_w;
	logic [AW-1:0]     ram_waddr_w;
	logic [AW-1:0]     ram_raddr_w;
	logic [15:0]       ram_rdata_w;

	assign ram_we_w    = state_q == ST_WRITE;
	assign ram_waddr_w = AW'(32'(ch_q) * WINDOW_MAX + 32'(heads_q[ch_q]));
	assign ram_raddr_w = AW'(32'(ch_q) * WINDOW_MAX + 32'(ptr_q));

	wstt_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we_w),
		.waddr(ram_waddr_w),
		.wdata(sample_q),
		.raddr(ram_raddr_w),
		.rdata(ram_rdata_w)
	);

	// Divider for the rounded quotient (2|num|*256 + den) / (2*den).
	logic             div_start_w;
	logic             div_done_w;
	logic             div_ovf_w;
	logic [QW-1:0]    div_quo_w;
	logic [DVD_W-1:0] div_dvd_w;
	logic [DVS_W-1:0] div_dvs_w;

	assign div_start_w = state_q == ST_START;
	assign div_dvd_w   = DVD_W'({mag_q, 9'b0}) + DVD_W'(den_q);
	assign div_dvs_w   = {den_q, 1'b0};

	wstt_divider #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W),
		.Q_W  (QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_w),
		.dividend(div_dvd_w),
		.divisor (div_dvs_w),
		.done    (div_done_w),
		.ovf     (div_ovf_w),
		.quotient(div_quo_w)
	);

	// Window clamped to 1..WINDOW_MAX, and the bookkeeping of the appended sample.
	logic [CW-1:0]   win_w;
	logic [CW:0]     cnt_inc_w;
	logic [CW-1:0]   n_new_w;
	logic [CW:0]     head_inc_w;
	logic [CW:0]     start_w;
	logic [IW-1:0]   head_next_w;
	logic [IW-1:0]   ptr_next_w;
	logic [IW-1:0]   x_w;
	logic [IW+15:0]  xy_w;
	logic            load_w;

	always_comb begin
		if (trend_window_q == 5'd0) begin
			win_w = CW'(1);
		end else if (32'(trend_window_q) > WINDOW_MAX) begin
			win_w = CW'(WINDOW_MAX);
		end else begin
			win_w = CW'(trend_window_q);
		end
		cnt_inc_w  = (CW + 1)'(counts_q[ch_q]) + (CW + 1)'(1);
		n_new_w    = ((CW + 1)'(win_w) < cnt_inc_w) ? win_w : cnt_inc_w[CW-1:0];
		head_inc_w = (CW + 1)'(heads_q[ch_q]) + (CW + 1)'(1);
		// Oldest kept entry sits n places behind the slot after the new one.
		if (head_inc_w >= (CW + 1)'(n_new_w)) begin
			start_w = head_inc_w - (CW + 1)'(n_new_w);
		end else begin
			start_w = head_inc_w + (CW + 1)'(WINDOW_MAX) - (CW + 1)'(n_new_w);
		end
		head_next_w = (32'(heads_q[ch_q]) == WINDOW_MAX - 1) ? '0 : heads_q[ch_q] + IW'(1);
		ptr_next_w  = (32'(ptr_q) == WINDOW_MAX - 1) ? '0 : ptr_q + IW'(1);
		x_w         = IW'(k_q - CW'(1));
		xy_w        = (IW + 16)'(x_w) * (IW + 16)'(ram_rdata_w);
	end

	assign load_w = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				heads_q[c]  <= '0;
				counts_q[c] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (32'(in_data.channel) >= NUM_CHANNELS) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					heads_q[ch_q]  <= head_next_w;
					counts_q[ch_q] <= n_new_w;
					k_q            <= '0;
					state_q        <= ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + CW'(1);
					if (k_q == n_q) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUB;
				ST_SUB: begin
					if (32'(n_q) < wstt_pkg::FIT_MIN_SAMPLES || p3_q <= p4_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done_w) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q     <= CHW'(in_data.channel);
				sample_q <= in_data.sample;
				// An out-of-range channel reports as an empty history.
				n_q      <= '0;
				slope_q  <= '0;
			end
			ST_WRITE: begin
				n_q   <= n_new_w;
				ptr_q <= IW'(start_w);
				sx_q  <= '0;
				sxx_q <= '0;
				sy_q  <= '0;
				sxy_q <= '0;
			end
			ST_READ: begin
				if (k_q != n_q) begin
					ptr_q <= ptr_next_w;
				end
				// RAM data is registered behind its address, so entry k-1 arrives now.
				if (k_q != '0) begin
					sx_q  <= sx_q + SX_W'(x_w);
					sxx_q <= sxx_q + SXX_W'(x_w) * SXX_W'(x_w);
					sy_q  <= sy_q + SY_W'(ram_rdata_w);
					sxy_q <= sxy_q + SXY_W'(xy_w);
				end
			end
			ST_MUL: begin
				p1_q <= P_W'(n_q) * P_W'(sxy_q);
				p2_q <= P_W'(sx_q) * P_W'(sy_q);
				p3_q <= DEN_W'(n_q) * DEN_W'(sxx_q);
				p4_q <= DEN_W'(sx_q) * DEN_W'(sx_q);
			end
			ST_SUB: begin
				neg_q   <= p2_q > p1_q;
				mag_q   <= (p1_q >= p2_q) ? p1_q - p2_q : p2_q - p1_q;
				den_q   <= p3_q - p4_q;
				slope_q <= '0;
			end
			ST_DIV: begin
				if (div_done_w) begin
					if (div_ovf_w || div_quo_w > wstt_pkg::SLOPE_LIMIT) begin
						slope_q <= neg_q ? SW'(0) - SW'(wstt_pkg::SLOPE_LIMIT)
						                 : SW'(wstt_pkg::SLOPE_LIMIT);
					end else begin
						slope_q <= neg_q ? SW'(0) - SW'(div_quo_w) : SW'(div_quo_w);
					end
				end
			end
			default: ;
		endcase
	end

	// Result fields from the final slope and sample count.
	logic [SW-1:0] slope_mag_w;
	logic          stagnant_w;
	logic          rising_w;
	logic [6:0]    md_w;
	logic [7:0]    span_w;
	logic [7:0]    depth_w;

	always_comb begin
		slope_mag_w = slope_q[SW-1] ? SW'(0) - slope_q : slope_q;
		stagnant_w  = (32'(n_q) >= wstt_pkg::STAG_MIN_SAMPLES)
		              && (slope_mag_w < SW'(stag_floor_q));
		rising_w    = !slope_q[SW-1] && (slope_q > SW'(stag_floor_q));
		md_w        = (max_depth_q == 7'd0) ? 7'd1 : max_depth_q;
		span_w      = 8'(n_q) - 8'd1;
		if (32'(n_q) < wstt_pkg::FIT_MIN_SAMPLES || rising_w) begin
			depth_w = 8'd1;
		end else if (span_w < 8'(md_w) - 8'd1) begin
			depth_w = span_w + 8'd1;
		end else begin
			depth_w = 8'(md_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_w) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_w) begin
			out_q.slope        <= slope_q;
			out_q.stagnant     <= stagnant_w;
			out_q.next_depth   <= depth_w[6:0];
			out_q.sample_count <= 5'(n_q);
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/wstt_checker.sv =====
// Port-level checker for the windowed slope trend tracker, bound to its top level.
// Depends on wstt_pkg and windowed_slope_trend_tracker_top.
`timescale 1ns / 1ps

module wstt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input wstt_pkg::out_item_t out_data
);

	// A result waiting for the consumer must not change under it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// Only one request is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in work");

	// Fewer than two samples give no slope and the shallowest depth.
	a_short_history: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.sample_count < 5'd2)
		|-> (out_data.slope == 26'sd0) && (out_data.next_depth == 7'd1))
		else $error("short history reported a slope or a deep depth");

	// Stagnation needs at least three samples.
	a_stagnant_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stagnant |-> out_data.sample_count >= 5'd3)
		else $error("stagnant flag raised on fewer than three samples");

	// Depth is never zero.
	a_depth_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.next_depth != 7'd0)
		else $error("zero practice depth returned");

endmodule

bind windowed_slope_trend_tracker_top wstt_checker u_wstt_checker (.*);

// ===== test/tb.sv =====
// Testbench of the windowed slope trend tracker: directed corners, a long output stall and
// random sample traffic, each result checked against a predictor of the least-squares fit.
// Depends on wstt_pkg and windowed_slope_trend_tracker_top.
`timescale 1ns / 1ps

module tb;

	localparam int NUM_CH         = 6;
	localparam int WIN_MAX        = 16;
	localparam int SETTLE_CYCLES  = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int STALL_LIMIT    = 3000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 100;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         psel     = 1'b0;
	logic                         penable  = 1'b0;
	logic                         pwrite   = 1'b0;
	logic [wstt_pkg::PADDR_W-1:0] paddr    = '0;
	logic [31:0]                  pwdata   = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	wstt_pkg::in_item_t           in_data  = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	wstt_pkg::out_item_t          out_data;

	// Mirror of the channel histories and the registers.
	logic [15:0] history [NUM_CH][WIN_MAX];
	int unsigned held [NUM_CH];
	int unsigned head [NUM_CH];
	int unsigned window_cfg = 32'(wstt_pkg::TREND_WINDOW_RST);
	int unsigned depth_cfg  = 32'(wstt_pkg::MAX_DEPTH_RST);
	int unsigned floor_cfg  = 32'(wstt_pkg::STAG_FLOOR_RST);

	wstt_pkg::out_item_t pending_fits [$];
	int        mismatches    = 0;
	int        requests_sent = 0;
	int        results_seen  = 0;
	int        reg_writes    = 0;
	bit        tx_idle       = 1'b1;
	bit        rx_idle       = 1'b1;
	bit        hold_pending  = 1'b0;

	always #10 clk = ~clk;

	windowed_slope_trend_tracker_top #(
		.NUM_CHANNELS(NUM_CH),
		.WINDOW_MAX  (WIN_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	function automatic int draw_wait(bit enabled);
		if (!enabled) begin
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Appends the sample to its channel and returns the fit over the kept history.
	function automatic wstt_pkg::out_item_t track_sample(wstt_pkg::in_item_t req);
		wstt_pkg::out_item_t res;
		int unsigned    ch, win, n, md, first, i;
		longint         sx, sy, sxy, sxx, nn, y, num, den, slope, mag;
		longint unsigned quo;
		res = '0;
		res.next_depth = 7'd1;
		ch = 32'(req.channel);
		if (ch >= NUM_CH) begin
			return res;
		end
		win = window_cfg;
		if (win < 1) begin
			win = 1;
		end
		if (win > WIN_MAX) begin
			win = WIN_MAX;
		end
		history[ch][head[ch]] = req.sample;
		head[ch] = (head[ch] + 1) % WIN_MAX;
		n = held[ch] + 1;
		if (n > win) begin
			n = win;
		end
		held[ch] = n;
		slope = 0;
		if (n >= wstt_pkg::FIT_MIN_SAMPLES) begin
			sx = 0;
			sy = 0;
			sxy = 0;
			sxx = 0;
			first = (head[ch] + WIN_MAX - n) % WIN_MAX;
			for (i = 0; i < n; i++) begin
				y = longint'(history[ch][(first + i) % WIN_MAX]);
				sx += longint'(i);
				sy += y;
				sxy += longint'(i) * y;
				sxx += longint'(i) * longint'(i);
			end
			nn = longint'(n);
			den = nn * sxx - sx * sx;
			if (den > 0) begin
				num = (nn * sxy - sx * sy) * 256;
				quo = (num < 0) ? -num : num;
				// Round to nearest, ties away from zero, on the magnitude.
				quo = (2 * quo + den) / (2 * den);
				if (quo > wstt_pkg::SLOPE_LIMIT) begin
					quo = wstt_pkg::SLOPE_LIMIT;
				end
				slope = (num < 0) ? -longint'(quo) : longint'(quo);
			end
		end
		mag = (slope < 0) ? -slope : slope;
		res.slope = slope[wstt_pkg::SLOPE_W-1:0];
		res.stagnant = (n >= wstt_pkg::STAG_MIN_SAMPLES) && (mag < longint'(floor_cfg));
		md = (depth_cfg < 1) ? 1 : depth_cfg;
		if (n < wstt_pkg::FIT_MIN_SAMPLES || slope > longint'(floor_cfg)) begin
			res.next_depth = 7'd1;
		end else begin
			res.next_depth = 7'(1 + ((n - 1 < md - 1) ? n - 1 : md - 1));
		end
		res.sample_count = 5'(n);
		return res;
	endfunction

	// Offers one request and records its expected result once it is accepted.
	// Valid is left high so that a request without a gap follows without a dip.
	task automatic send_sample(input logic [2:0] ch, input logic [15:0] smp);
		int                 gap;
		wstt_pkg::in_item_t req;
		gap = draw_wait(tx_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.channel = ch;
		req.sample = smp;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_fits.insert(pending_fits.size(), track_sample(req));
		requests_sent++;
	endtask

	// Stops offering and waits until every result is in and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_fits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			wstt_pkg::REG_TREND_WINDOW: window_cfg = 32'(val[4:0]);
			wstt_pkg::REG_MAX_DEPTH:    depth_cfg = 32'(val[6:0]);
			wstt_pkg::REG_STAG_FLOOR:   floor_cfg = 32'(val[15:0]);
			default:                    ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic apply_settings(input int unsigned win, input int unsigned dep,
			input int unsigned flr);
		write_reg(wstt_pkg::REG_TREND_WINDOW, win);
		write_reg(wstt_pkg::REG_MAX_DEPTH, dep);
		write_reg(wstt_pkg::REG_STAG_FLOOR, flr);
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Sample extremes, flat and falling histories, and channels out of range.
	task automatic test_field_extremes();
		send_sample(3'd0, 16'h0000);
		send_sample(3'd0, 16'hFFFF);
		send_sample(3'd0, 16'h0000);
		send_sample(3'd1, 16'hFFFF);
		send_sample(3'd1, 16'hFFFF);
		send_sample(3'd1, 16'hFFFF);
		send_sample(3'd5, 16'd40000);
		send_sample(3'd5, 16'd30001);
		send_sample(3'd5, 16'd20003);
		send_sample(3'd5, 16'd19998);
		send_sample(3'd6, 16'hFFFF);
		send_sample(3'd7, 16'h0000);
		settle();
	endtask

	// Zero window and depth, oversized window, then a window lowered under a longer history.
	task automatic test_config_corners();
		apply_settings(0, 0, 0);
		send_sample(3'd2, 16'd1234);
		send_sample(3'd2, 16'd4321);
		settle();
		apply_settings(31, 127, 65535);
		send_sample(3'd1, 16'hFFFF);
		send_sample(3'd1, 16'hFFFE);
		send_sample(3'd0, 16'd100);
		settle();
		apply_settings(2, 64, 17);
		send_sample(3'd1, 16'hFFFF);
		send_sample(3'd0, 16'h0000);
		settle();
	endtask

	// The output side holds off for a long stretch while requests keep coming.
	task automatic test_input_stall();
		int k;
		tx_idle = 1'b0;
		hold_pending = 1'b1;
		for (k = 0; k < 12; k++) begin
			send_sample(3'(k % NUM_CH), 16'($urandom_range(0, 65535)));
		end
		settle();
		tx_idle = 1'b1;
	endtask

	// Phases of drifting per-channel levels with noise, a few wild samples and
	// stray channels, under a fresh register setting each phase.
	task automatic test_random_traffic();
		int unsigned win, dep, flr, drift, noise;
		int          counted, ph, c;
		int          level [NUM_CH];
		int          trend [NUM_CH];
		logic [2:0]  ch;
		logic [15:0] smp;
		for (c = 0; c < NUM_CH; c++) begin
			level[c] = $urandom_range(0, 65535);
		end
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					win = 1;
					dep = 1;
					flr = 0;
				end
				1: begin
					win = 16;
					dep = 64;
					flr = 65535;
				end
				2: begin
					win = 31;
					dep = 127;
					flr = 17;
				end
				default: begin
					win = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
						: $urandom_range(2, 16);
					dep = $urandom_range(0, 127);
					case ($urandom_range(0, 3))
						0:       flr = 0;
						1:       flr = $urandom_range(1, 64);
						2:       flr = $urandom_range(0, 65535);
						default: flr = 65535;
					endcase
				end
			endcase
			case ($urandom_range(0, 4))
				0:       drift = 0;
				1:       drift = 1;
				2:       drift = 4;
				3:       drift = 64;
				default: drift = 4096;
			endcase
			noise = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
			for (c = 0; c < NUM_CH; c++) begin
				trend[c] = int'($urandom_range(0, 2 * drift)) - int'(drift);
			end
			tx_idle = (ph != 2) && ($urandom_range(0, 3) != 0);
			rx_idle = (ph != 2) && ($urandom_range(0, 3) != 0);
			apply_settings(win, dep, flr);
			counted = 0;
			while (counted < PHASE_REQUESTS) begin
				if ($urandom_range(0, 24) == 0) begin
					ch = 3'($urandom_range(NUM_CH, 7));
					smp = 16'($urandom_range(0, 65535));
				end else begin
					ch = 3'($urandom_range(0, NUM_CH - 1));
					counted++;
					if ($urandom_range(0, 9) == 0) begin
						smp = 16'($urandom_range(0, 65535));
					end else begin
						level[ch] += trend[ch] + int'($urandom_range(0, 2 * noise)) - int'(noise);
						if (level[ch] < 0) begin
							level[ch] = 0;
						end
						if (level[ch] > 65535) begin
							level[ch] = 65535;
						end
						smp = level[ch][15:0];
					end
				end
				send_sample(ch, smp);
			end
			settle();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin : result_sink
		int                  stall;
		wstt_pkg::out_item_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(rx_idle);
			if (hold_pending) begin
				stall = HOLD_CYCLES;
				hold_pending = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			results_seen++;
			if (pending_fits.size() == 0) begin
				$display("%0t ns: result with nothing expected, got slope %0d count %0d",
					$time, out_data.slope, out_data.sample_count);
				mismatches++;
			end else begin
				want = pending_fits.pop_front();
				compare_field("slope", want.slope, out_data.slope);
				compare_field("stagnant", want.stagnant, out_data.stagnant);
				compare_field("next_depth", want.next_depth, out_data.next_depth);
				compare_field("sample_count", want.sample_count, out_data.sample_count);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_config_corners();
		test_input_stall();
		test_random_traffic();
		if (pending_fits.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, pending_fits.size());
			mismatches++;
		end
		$display("Sent %0d requests, checked %0d results, made %0d register writes.",
			requests_sent, results_seen, reg_writes);
		$display("Covered stray channels, window and depth corners and a long output stall.");
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
